@@ rtl/ppmc_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and microcode table of the position move controller
package ppmc_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int INTEGRAL_WIDTH = 48;
    localparam int COUNT_WIDTH    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OPCODE_W   = 2;
    localparam int POS_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int SPEED_W    = 7;
    localparam int TOL_W      = 31;
    localparam int TICKS_W    = 16;
    localparam int DRIVE_W    = 8;
    localparam int ERR_W      = POS_W + 1;
    localparam int DERR_W     = ERR_W + 1;

    // multiplier operand is split into a signed high chunk and a zero-extended low chunk
    localparam int OPND_RAW_W = (INTEGRAL_WIDTH > DERR_W) ? INTEGRAL_WIDTH : DERR_W;
    localparam int OPND_W     = OPND_RAW_W + (OPND_RAW_W % 2);
    localparam int HALF_W     = OPND_W / 2;
    localparam int CHUNK_W    = HALF_W + 1;
    localparam int PROD_W     = GAIN_W + CHUNK_W;
    localparam int ACC_W      = GAIN_W + OPND_W + 3;
    localparam int CV_W       = FRAC_BITS + 2;
    localparam int CMP_W      = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
    localparam int PC_W       = 4;

    localparam logic [SPEED_W-1:0] SPEED_FULL = SPEED_W'(100);
    localparam logic [PC_W-1:0]    PC_FINISH  = PC_W'(10);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P        = 3'd0,
        CFG_GAIN_I        = 3'd1,
        CFG_GAIN_D        = 3'd2,
        CFG_SPEED_PCT     = 3'd3,
        CFG_TARGET_POS    = 3'd4,
        CFG_TOLERANCE     = 3'd5,
        CFG_TIMEOUT_TICKS = 3'd6,
        CFG_SETTLE_TICKS  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MSRC_NONE,
        MSRC_P,
        MSRC_I,
        MSRC_D,
        MSRC_SCALE
    } t_mul_src;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PREP,
        ACT_CLAMP,
        ACT_FINISH
    } t_act;

    typedef struct packed {
        t_act            act;
        t_mul_src        src;
        logic            mul_hi;
        logic            acc_en;
        logic            acc_hi;
        logic            jmp_idle;
        logic [PC_W-1:0] target;
    } t_uword;

    // control store: prepare, six partial products, clamp, scale, finish
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{act: ACT_NONE, src: MSRC_NONE, mul_hi: 1'b0, acc_en: 1'b0,
              acc_hi: 1'b0, jmp_idle: 1'b0, target: '0};
        unique case (pc)
            4'd0: begin
                w.act      = ACT_PREP;
                w.jmp_idle = 1'b1;
                w.target   = PC_FINISH;
            end
            4'd1: begin
                w.src = MSRC_P;
            end
            4'd2: begin
                w.src    = MSRC_P;
                w.mul_hi = 1'b1;
                w.acc_en = 1'b1;
            end
            4'd3: begin
                w.src    = MSRC_I;
                w.acc_en = 1'b1;
                w.acc_hi = 1'b1;
            end
            4'd4: begin
                w.src    = MSRC_I;
                w.mul_hi = 1'b1;
                w.acc_en = 1'b1;
            end
            4'd5: begin
                w.src    = MSRC_D;
                w.acc_en = 1'b1;
                w.acc_hi = 1'b1;
            end
            4'd6: begin
                w.src    = MSRC_D;
                w.mul_hi = 1'b1;
                w.acc_en = 1'b1;
            end
            4'd7: begin
                w.acc_en = 1'b1;
                w.acc_hi = 1'b1;
            end
            4'd8: begin
                w.act = ACT_CLAMP;
            end
            4'd9: begin
                w.src = MSRC_SCALE;
            end
            default: begin
                w.act = ACT_FINISH;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/ppmc_in_if.sv @@
`timescale 1ns / 1ps
// command channel: opcode and measured position
interface ppmc_in_if;
    import ppmc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic signed [POS_W-1:0] measured_pos;

    modport source (output valid, output opcode, output measured_pos, input ready);
    modport sink   (input valid, input opcode, input measured_pos, output ready);
endinterface

@@ rtl/ppmc_out_if.sv @@
`timescale 1ns / 1ps
// result channel: drive command and move status
interface ppmc_out_if;
    import ppmc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_pct;
    logic                      drive_update;
    logic                      running;
    logic                      target_reached;
    logic                      finished;
    logic                      settled;

    modport source (output valid, output drive_pct, output drive_update, output running,
                    output target_reached, output finished, output settled, input ready);
    modport sink   (input valid, input drive_pct, input drive_update, input running,
                    input target_reached, input finished, input settled, output ready);
endinterface

@@ rtl/pid_position_move_controller.sv @@
`timescale 1ns / 1ps
// pid position move controller with settle and timeout, microcoded around one multiplier
// a tick while running steps the 11-word control store from prepare to finish, where its result is registered;
// start, stop, idle ticks and the reserved opcode jump from prepare straight to finish
// the shared 32 x 25 multiplier serves six partial products plus the scaling
// one item is in work at a time; the next is taken the cycle after the result is loaded
// synchronous active-low reset clears control, controller state and configuration registers (speed_pct to 100)
module pid_position_move_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ppmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ppmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ppmc_in_if.sink                           i_cmd,
    ppmc_out_if.source                        o_res
);
    import ppmc_pkg::*;

    localparam logic signed [ACC_W-1:0] ONE_ACC     = ACC_W'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] NEG_ONE_ACC = -ONE_ACC;

    // configuration
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [POS_W-1:0]  r_target_pos;
    logic [SPEED_W-1:0]       r_speed_pct;
    logic [TOL_W-1:0]         r_tolerance;
    logic [TICKS_W-1:0]       r_timeout_ticks, r_settle_ticks;

    // sequencer and item
    logic                     r_busy, n_busy;
    logic [PC_W-1:0]          r_pc, n_pc;
    t_opcode                  r_op;
    logic signed [ERR_W-1:0]  r_err;
    logic                     r_reached;

    // controller state
    logic signed [INTEGRAL_WIDTH-1:0] r_integ;
    logic signed [ERR_W-1:0]          r_last_err;
    logic signed [DERR_W-1:0]         r_derr;
    logic [COUNT_WIDTH-1:0]           r_elapsed, r_settle;
    logic                             r_run;

    // datapath
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [CV_W-1:0]   r_cv;

    // result register
    logic                      r_out_valid, n_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_upd, r_running, r_out_reached, r_fin, r_stl;

    t_uword uw;
    logic   accept, out_free, is_work, load_out;

    logic signed [ERR_W-1:0]            err_in;
    logic [ERR_W-1:0]                   abs_err;
    logic                               reached_in;
    logic signed [INTEGRAL_WIDTH:0]     integ_sum;
    logic signed [INTEGRAL_WIDTH-1:0]   integ_sat;
    logic signed [DERR_W-1:0]           derr_c;
    logic signed [OPND_W-1:0]           opnd;
    logic signed [GAIN_W-1:0]           mul_a;
    logic signed [CHUNK_W-1:0]          mul_b;
    logic signed [PROD_W-1:0]           prod_c;
    logic signed [ACC_W-1:0]            prod_ext, addend;
    logic signed [ACC_W-1:0]            acc_shr;
    logic signed [CV_W-1:0]             cv_c;
    logic signed [CV_W-1:0]             cv_neg;
    logic [CV_W-2:0]                    cv_mag;
    logic [SPEED_W-1:0]                 speed_eff;
    logic [SPEED_W-1:0]                 drive_mag;
    logic signed [DRIVE_W-1:0]          drive_c;
    logic [COUNT_WIDTH-1:0]             elapsed_nx, settle_nx;
    logic                               by_settle, by_time, move_end;

    assign uw       = ucode(r_pc);
    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign is_work  = (r_op == OP_TICK) && r_run;
    assign load_out = r_busy && (uw.act == ACT_FINISH) && out_free;

    // no transaction is taken while reset is held
    assign i_cmd.ready          = i_rst_n && !r_busy;
    assign o_res.valid          = r_out_valid;
    assign o_res.drive_pct      = r_drive;
    assign o_res.drive_update   = r_upd;
    assign o_res.running        = r_running;
    assign o_res.target_reached = r_out_reached;
    assign o_res.finished       = r_fin;
    assign o_res.settled        = r_stl;

    // error and tolerance check on the incoming position
    always_comb begin
        err_in     = ERR_W'(r_target_pos) - ERR_W'(i_cmd.measured_pos);
        abs_err    = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
        reached_in = ERR_W'(r_tolerance) > abs_err;
    end

    // integral with saturation, error difference
    always_comb begin
        integ_sum = (INTEGRAL_WIDTH + 1)'(r_integ) + (INTEGRAL_WIDTH + 1)'(r_err);
        if (integ_sum[INTEGRAL_WIDTH] != integ_sum[INTEGRAL_WIDTH-1]) begin
            integ_sat = {integ_sum[INTEGRAL_WIDTH], {(INTEGRAL_WIDTH-1){~integ_sum[INTEGRAL_WIDTH]}}};
        end else begin
            integ_sat = integ_sum[INTEGRAL_WIDTH-1:0];
        end
        derr_c = DERR_W'(r_err) - DERR_W'(r_last_err);
    end

    // shared multiplier operand selection
    always_comb begin
        cv_neg    = -r_cv;
        cv_mag    = r_cv[CV_W-1] ? cv_neg[CV_W-2:0] : r_cv[CV_W-2:0];
        speed_eff = (r_speed_pct > SPEED_FULL) ? SPEED_FULL : r_speed_pct;
        opnd      = '0;
        mul_a     = '0;
        case (uw.src)
            MSRC_P: begin
                mul_a = r_gain_p;
                opnd  = OPND_W'(r_err);
            end
            MSRC_I: begin
                mul_a = r_gain_i;
                opnd  = OPND_W'(r_integ);
            end
            MSRC_D: begin
                mul_a = r_gain_d;
                opnd  = OPND_W'(r_derr);
            end
            MSRC_SCALE: begin
                mul_a = $signed(GAIN_W'(cv_mag));
            end
            default: begin
                mul_a = '0;
            end
        endcase
        if (uw.src == MSRC_SCALE) begin
            mul_b = $signed(CHUNK_W'(speed_eff));
        end else if (uw.mul_hi) begin
            mul_b = {opnd[OPND_W-1], opnd[OPND_W-1:HALF_W]};
        end else begin
            mul_b = {1'b0, opnd[HALF_W-1:0]};
        end
        prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // accumulate, clamp and drive
    always_comb begin
        prod_ext = ACC_W'(r_prod);
        addend   = uw.acc_hi ? (prod_ext <<< HALF_W) : prod_ext;
        acc_shr  = r_acc >>> FRAC_BITS;
        if (acc_shr > ONE_ACC) begin
            cv_c = CV_W'(ONE_ACC);
        end else if (acc_shr < NEG_ONE_ACC) begin
            cv_c = CV_W'(NEG_ONE_ACC);
        end else begin
            cv_c = acc_shr[CV_W-1:0];
        end
        drive_mag = r_prod[FRAC_BITS +: SPEED_W];
        drive_c   = r_cv[CV_W-1] ? -$signed({1'b0, drive_mag}) : $signed({1'b0, drive_mag});
    end

    // tick counters and end of move
    always_comb begin
        elapsed_nx = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        if (r_reached) begin
            settle_nx = (&r_settle) ? r_settle : r_settle + 1'b1;
        end else begin
            settle_nx = '0;
        end
        by_settle = CMP_W'(settle_nx) >= CMP_W'(r_settle_ticks);
        by_time   = CMP_W'(elapsed_nx) >= CMP_W'(r_timeout_ticks);
        move_end  = (r_timeout_ticks != '0) && (by_settle || by_time);
    end

    // step counter
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (accept) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else if (uw.act == ACT_FINISH) begin
            if (out_free) begin
                n_busy = 1'b0;
            end
        end else if (uw.jmp_idle && !is_work) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p        <= '0;
            r_gain_i        <= '0;
            r_gain_d        <= '0;
            r_speed_pct     <= SPEED_FULL;
            r_target_pos    <= '0;
            r_tolerance     <= '0;
            r_timeout_ticks <= '0;
            r_settle_ticks  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:        r_gain_p        <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_GAIN_I:        r_gain_i        <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_GAIN_D:        r_gain_d        <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_SPEED_PCT:     r_speed_pct     <= i_cfg_data[SPEED_W-1:0];
                CFG_TARGET_POS:    r_target_pos    <= $signed(i_cfg_data[POS_W-1:0]);
                CFG_TOLERANCE:     r_tolerance     <= i_cfg_data[TOL_W-1:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[TICKS_W-1:0];
                CFG_SETTLE_TICKS:  r_settle_ticks  <= i_cfg_data[TICKS_W-1:0];
            endcase
        end
    end

    // item capture and datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= t_opcode'(i_cmd.opcode);
            r_err     <= err_in;
            r_reached <= reached_in;
        end
        if (r_busy) begin
            // the scaled product is held while the result waits
            if (uw.src != MSRC_NONE) begin
                r_prod <= prod_c;
            end
            if (uw.act == ACT_PREP) begin
                r_acc <= '0;
            end else if (uw.acc_en) begin
                r_acc <= r_acc + addend;
            end
            if (uw.act == ACT_CLAMP) begin
                r_cv <= cv_c;
            end
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
            r_derr     <= '0;
            r_elapsed  <= '0;
            r_settle   <= '0;
            r_run      <= 1'b0;
        end else if (r_busy && uw.act == ACT_PREP) begin
            if (is_work) begin
                r_integ <= integ_sat;
                r_derr  <= derr_c;
            end else if (r_op == OP_START) begin
                r_integ    <= '0;
                r_elapsed  <= '0;
                r_settle   <= '0;
                r_last_err <= r_err;
                r_run      <= 1'b1;
            end else if (r_op == OP_STOP) begin
                r_run <= 1'b0;
            end
        end else if (load_out && is_work) begin
            r_last_err <= r_err;
            r_elapsed  <= elapsed_nx;
            r_settle   <= settle_nx;
            if (move_end) begin
                r_run <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_reached <= r_reached;
            if (is_work) begin
                r_drive   <= drive_c;
                r_upd     <= 1'b1;
                r_running <= !move_end;
                r_fin     <= move_end;
                r_stl     <= move_end && by_settle;
            end else begin
                r_drive   <= '0;
                r_upd     <= 1'b0;
                r_running <= r_run;
                r_fin     <= 1'b0;
                r_stl     <= 1'b0;
            end
        end
    end

    // checks
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.drive_pct <= 8'sd100 && o_res.drive_pct >= -8'sd100))
        else $error("drive outside percent range");

    a_no_drive_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.drive_update) |-> (o_res.drive_pct == '0 && !o_res.finished))
        else $error("drive or finish reported on an item without a control step");

    a_finish_stops_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.finished) |-> !o_res.running)
        else $error("move finished but still running");

    a_settle_needs_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.settled) |-> o_res.finished)
        else $error("settled without finish");

    a_load_frees_sequencer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (!r_busy && r_out_valid))
        else $error("sequencer still busy after result transaction loaded");

endmodule

@@ verif/pid_position_move_controller_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the pid position move controller: directed and random moves
import ppmc_pkg::*;

localparam longint INTEG_MAX = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1;
localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;
localparam longint CV_ONE    = 64'sd1 <<< FRAC_BITS;
localparam longint COUNT_MAX = (64'sd1 <<< COUNT_WIDTH) - 64'sd1;

typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_pct;
    logic                      drive_update;
    logic                      running;
    logic                      target_reached;
    logic                      finished;
    logic                      settled;
} t_move_result;

class move_scoreboard;
    logic signed [GAIN_W-1:0] kp, ki, kd;
    logic [SPEED_W-1:0]       speed;
    logic signed [POS_W-1:0]  target;
    logic [TOL_W-1:0]         tol;
    logic [TICKS_W-1:0]       timeout_lim, settle_lim;

    longint last_err, integ, elapsed, settle_cnt;
    bit     moving;

    t_move_result drive_q[$];
    int errors, n_checked, n_active, n_finished, n_settled;

    function new();
        kp = '0; ki = '0; kd = '0; speed = SPEED_FULL; target = '0; tol = '0;
        timeout_lim = '0; settle_lim = '0;
        last_err = 0; integ = 0; elapsed = 0; settle_cnt = 0; moving = 1'b0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_P:        kp = data[GAIN_W-1:0];
            CFG_GAIN_I:        ki = data[GAIN_W-1:0];
            CFG_GAIN_D:        kd = data[GAIN_W-1:0];
            CFG_SPEED_PCT:     speed = data[SPEED_W-1:0];
            CFG_TARGET_POS:    target = data[POS_W-1:0];
            CFG_TOLERANCE:     tol = data[TOL_W-1:0];
            CFG_TIMEOUT_TICKS: timeout_lim = data[TICKS_W-1:0];
            CFG_SETTLE_TICKS:  settle_lim = data[TICKS_W-1:0];
            default: ;
        endcase
    endfunction

    function logic signed [127:0] mul_wide(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [127:0] x, y;
        x = a;
        y = b;
        return x * y;
    endfunction

    // works out the result of one accepted command and queues it
    function void note_command(t_opcode op, logic signed [POS_W-1:0] pos);
        longint err, aerr, cv, mag, lim;
        logic signed [127:0] acc;
        t_move_result r;
        err  = longint'(target) - longint'(pos);
        aerr = (err < 0) ? -err : err;
        r = '0;
        r.target_reached = longint'(tol) > aerr;
        case (op)
            OP_START: begin
                integ = 0;
                elapsed = 0;
                settle_cnt = 0;
                last_err = err;
                moving = 1'b1;
                n_active++;
            end
            OP_STOP: begin
                moving = 1'b0;
                n_active++;
            end
            OP_TICK: if (moving) begin
                n_active++;
                integ = integ + err;
                if (integ > INTEG_MAX)
                    integ = INTEG_MAX;
                else if (integ < INTEG_MIN)
                    integ = INTEG_MIN;
                acc = mul_wide(kp, err) + mul_wide(ki, integ) + mul_wide(kd, err - last_err);
                acc = acc >>> FRAC_BITS;
                if (acc > CV_ONE)
                    cv = CV_ONE;
                else if (acc < -CV_ONE)
                    cv = -CV_ONE;
                else
                    cv = longint'(acc);
                lim = (speed > SPEED_FULL) ? longint'(SPEED_FULL) : longint'(speed);
                mag = (((cv < 0) ? -cv : cv) * lim) >>> FRAC_BITS;
                r.drive_pct = DRIVE_W'((cv < 0) ? -mag : mag);
                r.drive_update = 1'b1;
                last_err = err;
                if (elapsed < COUNT_MAX)
                    elapsed++;
                if (longint'(tol) > aerr) begin
                    if (settle_cnt < COUNT_MAX)
                        settle_cnt++;
                end else begin
                    settle_cnt = 0;
                end
                // zero timeout holds position, nothing ends the move
                if (timeout_lim != 0 &&
                    (settle_cnt >= settle_lim || elapsed >= timeout_lim)) begin
                    r.finished = 1'b1;
                    r.settled = settle_cnt >= settle_lim;
                    moving = 1'b0;
                    n_finished++;
                    if (r.settled)
                        n_settled++;
                end
            end
            default: ;
        endcase
        r.running = moving;
        drive_q.push_back(r);
    endfunction

    function void cmp_field(string fname, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endfunction

    function void check_result(t_move_result got);
        t_move_result want;
        if (drive_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, drive_pct %0d", $time,
                     got.drive_pct);
            return;
        end
        want = drive_q.pop_front();
        n_checked++;
        cmp_field("drive_pct", want.drive_pct, got.drive_pct);
        cmp_field("drive_update", want.drive_update, got.drive_update);
        cmp_field("running", want.running, got.running);
        cmp_field("target_reached", want.target_reached, got.target_reached);
        cmp_field("finished", want.finished, got.finished);
        cmp_field("settled", want.settled, got.settled);
    endfunction

    function int pending();
        return drive_q.size();
    endfunction
endclass

module pid_position_move_controller_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 85;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ppmc_in_if  cmd_if ();
    ppmc_out_if res_if ();

    pid_position_move_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    move_scoreboard sb = new();

    logic [CFG_DATA_W-1:0] cfg_val [1 << CFG_IDX_W];
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;
    bit hold_req   = 1'b0;
    int n_cmds     = 0;
    int n_cfgs     = 0;
    int n_holds    = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int idle_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void fill_regs(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                                      logic [31:0] spd, logic [31:0] tgt, logic [31:0] tl,
                                      logic [31:0] tmo, logic [31:0] stl);
        cfg_val[CFG_GAIN_P]        = gp;
        cfg_val[CFG_GAIN_I]        = gi;
        cfg_val[CFG_GAIN_D]        = gd;
        cfg_val[CFG_SPEED_PCT]     = spd;
        cfg_val[CFG_TARGET_POS]    = tgt;
        cfg_val[CFG_TOLERANCE]     = tl;
        cfg_val[CFG_TIMEOUT_TICKS] = tmo;
        cfg_val[CFG_SETTLE_TICKS]  = stl;
    endfunction

    // upper bits beyond the register width must be dropped by the block
    function automatic logic [31:0] junk_above(logic [31:0] v, int w);
        if ($urandom_range(3) == 0)
            return v | ($urandom() << w);
        return v;
    endfunction

    function automatic logic [31:0] rand_gain();
        int r;
        logic [31:0] g;
        r = $urandom_range(9);
        g = $urandom_range(32'h0003_0000);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return r[0] ? -g : g;
        endcase
    endfunction

    function automatic void rand_regs();
        int r;
        logic [31:0] tgt, tl, tmo, stl, spd;
        spd = ($urandom_range(9) < 7) ? $urandom_range(100) : $urandom_range(127, 101);
        tgt = $urandom_range(32'h0010_0000);
        if ($urandom_range(9) < 7)
            tgt = $urandom_range(1) ? -tgt : tgt;
        else
            tgt = $urandom();
        r = $urandom_range(9);
        if (r < 6)
            tl = $urandom_range(32'h0004_0000, 32'h0000_0100);
        else if (r == 6)
            tl = '0;
        else if (r == 7)
            tl = $urandom() >> 1;
        else if (r == 8)
            tl = 32'h7FFF_FFFF;
        else
            tl = $urandom_range(32'h0000_4000);
        r = $urandom_range(9);
        if (r < 5)
            tmo = $urandom_range(12, 1);
        else if (r < 7)
            tmo = '0;
        else if (r == 7)
            tmo = 32'h0000_FFFF;
        else
            tmo = $urandom_range(40, 13);
        r = $urandom_range(9);
        if (r < 7)
            stl = $urandom_range(4);
        else if (r == 7)
            stl = 32'h0000_FFFF;
        else if (r == 8)
            stl = $urandom_range(65535);
        else
            stl = $urandom_range(12, 5);
        fill_regs(rand_gain(), rand_gain(), rand_gain(), junk_above(spd, SPEED_W), tgt,
                  junk_above(tl, TOL_W), junk_above(tmo, TICKS_W), junk_above(stl, TICKS_W));
    endfunction

    // position around the target: within tolerance or on its edge, near it, anywhere, or at the rails
    function automatic logic [31:0] pick_pos();
        int r;
        logic [31:0] mag;
        logic [31:0] tl;
        r = $urandom_range(99);
        tl = {1'b0, cfg_val[CFG_TOLERANCE][TOL_W-1:0]};
        if (r < 45)
            mag = $urandom_range(tl);
        else if (r < 80)
            mag = $urandom_range(32'h0008_0000);
        else if (r < 93)
            return $urandom();
        else
            return r[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return cfg_val[CFG_TARGET_POS] - ($urandom_range(1) ? mag : -mag);
    endfunction

    task automatic program_regs();
        t_cfg_idx idx;
        idx = idx.first();
        do begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= cfg_val[idx];
            @(posedge i_clk);
            sb.write_reg(idx, cfg_val[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_we <= 1'b0;
        n_cfgs++;
    endtask

    task automatic send_cmd(input t_opcode op, input logic [POS_W-1:0] pos);
        int gap;
        gap = idle_gap(send_quiet);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.measured_pos <= pos;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        sb.note_command(op, pos);
        n_cmds++;
    endtask

    // let every outstanding result come back so registers can be rewritten
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        int stop_at, k, r;
        stop_at = n_cmds + n_items;
        while (n_cmds < stop_at) begin
            if ($urandom_range(99) < 85) begin
                send_cmd(OP_START, pick_pos());
                k = $urandom_range(14, 1);
                repeat (k) begin
                    r = $urandom_range(99);
                    if (r < 4)
                        send_cmd(OP_RSVD, $urandom());
                    else if (r < 7)
                        send_cmd(OP_STOP, pick_pos());
                    else if (r < 9)
                        send_cmd(OP_START, pick_pos());
                    else
                        send_cmd(OP_TICK, pick_pos());
                end
            end else begin
                send_cmd(t_opcode'($urandom_range(3)), $urandom());
            end
        end
    endtask

    initial begin : result_sink
        int gap;
        t_move_result got;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
                n_holds++;
            end else begin
                gap = idle_gap(recv_quiet);
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.drive_pct      = res_if.drive_pct;
            got.drive_update   = res_if.drive_update;
            got.running        = res_if.running;
            got.target_reached = res_if.target_reached;
            got.finished       = res_if.finished;
            got.settled        = res_if.settled;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int p;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_GAIN_P;
        i_cfg_data          <= '0;
        cmd_if.valid        <= 1'b0;
        cmd_if.opcode       <= OP_TICK;
        cmd_if.measured_pos <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // timed move: idle commands, rails, tolerance edge, timeout, restart, settle, stop
        fill_regs(32'h0001_0000, 32'h0000_0100, 32'h0000_4000, SPEED_FULL, 32'h0002_0000,
                  32'h0000_8000, 32'd4, 32'd2);
        program_regs();
        send_cmd(OP_TICK, 32'h0000_0000);
        send_cmd(OP_RSVD, 32'h7FFF_FFFF);
        send_cmd(OP_STOP, 32'h8000_0000);
        send_cmd(OP_START, 32'h0000_0000);
        send_cmd(OP_TICK, 32'h8000_0000);
        send_cmd(OP_TICK, 32'h7FFF_FFFF);
        send_cmd(OP_RSVD, 32'h0001_C000);
        send_cmd(OP_TICK, 32'h0001_8000);
        send_cmd(OP_TICK, 32'h0001_C000);
        send_cmd(OP_START, 32'h0001_0000);
        send_cmd(OP_START, 32'h0002_4000);
        send_cmd(OP_TICK, 32'h0002_0000);
        send_cmd(OP_TICK, 32'h0001_F000);
        send_cmd(OP_TICK, 32'h0000_0000);
        send_cmd(OP_START, 32'h0000_0000);
        send_cmd(OP_TICK, 32'h0001_0000);
        send_cmd(OP_STOP, 32'h0001_0000);
        send_cmd(OP_TICK, 32'h0000_0000);
        drain();

        // gain rails, speed above full scale, settle and timeout on the same tick
        fill_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_007F, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'd1, 32'd1);
        program_regs();
        send_cmd(OP_START, 32'h7FFF_FFFF);
        send_cmd(OP_TICK, 32'h7FFF_FFFF);
        send_cmd(OP_START, 32'h0000_0000);
        send_cmd(OP_TICK, 32'h8000_0000);
        drain();

        // hold mode: settled but never finishes until stopped
        fill_regs(32'h0000_8000, 32'hFFFF_FF00, 32'h0001_0000, 32'd37, 32'hFFFF_0000,
                  32'h0001_0000, 32'd0, 32'd0);
        program_regs();
        send_cmd(OP_START, 32'h0000_0000);
        send_cmd(OP_TICK, 32'hFFFF_8000);
        send_cmd(OP_TICK, 32'hFFFF_0000);
        send_cmd(OP_TICK, 32'hFFFE_C000);
        send_cmd(OP_STOP, 32'hFFFF_0000);
        drain();

        // zero settle ticks end a timed move on its first tick, speed zero
        cfg_val[CFG_SPEED_PCT]     = 32'd0;
        cfg_val[CFG_TIMEOUT_TICKS] = 32'd3;
        program_regs();
        send_cmd(OP_START, 32'h4000_0000);
        send_cmd(OP_TICK, 32'h4000_0000);
        drain();

        for (p = 0; p < PHASES; p++) begin
            if (p == 0)
                fill_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'h8000_0000,
                          32'd0, 32'd0, 32'd0);
            else if (p == 1)
                fill_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_007F,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
            else
                rand_regs();
            program_regs();
            send_quiet = (p % 4 == 2) || (p == 3);
            recv_quiet = (p % 4 == 2);
            // back-pressure: receiver holds off a long while, so offered commands stall behind the held result
            if (p == 3)
                hold_req = 1'b1;
            random_phase(PHASE_ITEMS);
            drain();
        end

        repeat (30) @(posedge i_clk);
        $display("covered %0d commands (%0d acting on a move) over %0d register settings",
                 n_cmds, sb.n_active, n_cfgs);
        $display("%0d results compared, %0d moves ended (%0d settled), %0d long hold-offs",
                 sb.n_checked, sb.n_finished, sb.n_settled, n_holds);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ppmc_pkg.sv
rtl/ppmc_in_if.sv
rtl/ppmc_out_if.sv
rtl/pid_position_move_controller.sv
verif/pid_position_move_controller_tb.sv
